// File: hw/rtl/srms_pkg.sv
// Shared types and constants for the serial register mirror block.
package srms_pkg;

    localparam int unsigned DEVICE_COUNT_DEF = 16;
    localparam int unsigned MASK_W           = 16;
    localparam int unsigned RES_DEPTH        = 3;

    localparam logic [7:0] MARKER_BYTE  = 8'hff;
    localparam logic [7:0] MAG_INVALID  = 8'hff;
    localparam logic [7:0] MAG_TX_CLAMP = 8'hfe;
    localparam logic [3:0] FIELD_BAD    = 4'hf;

    typedef enum logic [1:0] {
        ACT_RX_BYTE   = 2'd0,
        ACT_SET_LOCAL = 2'd1,
        ACT_SCAN      = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_TX_BYTE  = 2'd0,
        KIND_READ     = 2'd1,
        KIND_ACCEPTED = 2'd2,
        KIND_REJECTED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ADDR = 2'd1,
        PH_MAG  = 2'd2
    } phase_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] rx_byte;
        logic [3:0] device;
        logic [3:0] mode;
        logic [7:0] magnitude;
    } cmd_t;

    typedef struct packed {
        kind_t      out_kind;
        logic [7:0] tx_byte;
        logic [3:0] remote_mode;
        logic [7:0] remote_magnitude;
        logic [3:0] local_mode;
        logic [7:0] local_magnitude;
        logic       bad_device;
        logic       bad_mode;
        logic       bad_magnitude;
        logic       last;
    } res_t;

endpackage

// File: hw/rtl/srms_cmd_if.sv
// Input item channel: valid/ready handshake with the command fields.
interface srms_cmd_if;
    logic              valid;
    logic              ready;
    srms_pkg::action_t action;
    logic [7:0]        rx_byte;
    logic [3:0]        device;
    logic [3:0]        mode;
    logic [7:0]        magnitude;

    modport source (output valid, action, rx_byte, device, mode, magnitude, input ready);
    modport sink   (input valid, action, rx_byte, device, mode, magnitude, output ready);
endinterface

// File: hw/rtl/srms_res_if.sv
// Result item channel: valid/ready handshake with the result fields.
interface srms_res_if;
    logic            valid;
    logic            ready;
    srms_pkg::kind_t out_kind;
    logic [7:0]      tx_byte;
    logic [3:0]      remote_mode;
    logic [7:0]      remote_magnitude;
    logic [3:0]      local_mode;
    logic [7:0]      local_magnitude;
    logic            bad_device;
    logic            bad_mode;
    logic            bad_magnitude;
    logic            last;

    modport source (output valid, out_kind, tx_byte, remote_mode, remote_magnitude,
                    local_mode, local_magnitude, bad_device, bad_mode, bad_magnitude,
                    last, input ready);
    modport sink   (input valid, out_kind, tx_byte, remote_mode, remote_magnitude,
                    local_mode, local_magnitude, bad_device, bad_mode, bad_magnitude,
                    last, output ready);
endinterface

// File: hw/rtl/serial_register_mirror_sync.sv
// Top level of the serial register mirror: parser, scanner and mirror tables.
//
//  Channel  | Direction | Handshake    | Contents
//  ---------+-----------+--------------+---------------------------------------------
//  cmd      | in        | valid/ready  | action, rx_byte, device, mode, magnitude
//  res      | out       | valid/ready  | out_kind, tx_byte, copies, error flags, last
//  cfg      | in        | write enable | writable_mask (16 bits), no read-back
//
// An accepted item sits in the input register and is processed as soon as the result
// buffer can take its results. Items with zero or one result flow at one item per cycle
// while the result side does not stall; a scan tick that transmits a packet leaves three
// results, so the next item waits until the three-entry result buffer has drained to its
// last entry. The result buffer delivers one item per cycle while res.ready is high.
// Reset (rst_n low, asynchronous) clears all four tables, the parser and the scan
// pointer at once; no clearing pass is needed. A stalled result side backs up into the
// input register and then drops cmd.ready.
module serial_register_mirror_sync #(
    parameter int unsigned DEVICE_COUNT = srms_pkg::DEVICE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    srms_cmd_if.sink                      cmd,
    srms_res_if.source                    res,
    input  logic                          cfg_wr_en,
    input  logic [srms_pkg::MASK_W-1:0]   cfg_wr_data
);

    // Table index width; the device field itself is always four bits wide.
    localparam int unsigned IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam logic [4:0]  DEV_LIMIT = 5'(DEVICE_COUNT);

    // Mirror tables, one entry per device.
    logic [3:0] rmode_reg [DEVICE_COUNT];
    logic [7:0] rmag_reg  [DEVICE_COUNT];
    logic [3:0] lmode_reg [DEVICE_COUNT];
    logic [7:0] lmag_reg  [DEVICE_COUNT];

    // Parser, scanner and configuration state.
    srms_pkg::phase_t            phase_reg, phase_next;
    logic [7:0]                  held_reg, held_next;
    logic [3:0]                  scan_ptr_reg, scan_ptr_next;
    logic [srms_pkg::MASK_W-1:0] mask_reg;

    // Input register.
    logic           item_valid_reg;
    srms_pkg::cmd_t item_reg;

    // Result buffer; entry 0 is presented on the output channel.
    srms_pkg::res_t res_buf_reg [srms_pkg::RES_DEPTH];
    logic [1:0]     pend_reg;

    // Outcome of processing the held item.
    srms_pkg::res_t new_res [srms_pkg::RES_DEPTH];
    logic [1:0]     new_cnt;

    // Table write ports.
    logic             rwr_en, lwr_en;
    logic [IDX_W-1:0] rwr_idx, lwr_idx;
    logic [3:0]       rwr_mode, lwr_mode;
    logic [7:0]       rwr_mag, lwr_mag;

    logic fire;
    logic pop;

    // Scan pointer cleanup: anything outside one to DEVICE_COUNT-1 acts as one.
    logic       scan_ok;
    logic [3:0] scan_p;
    logic [4:0] scan_inc;
    logic [3:0] scan_nx;

    // Read side: one address per cycle, chosen by the action.
    logic [3:0] rd_dev;
    logic       rd_in_range;
    logic [3:0] rd_rmode, rd_lmode;
    logic [7:0] rd_rmag, rd_lmag;

    // Packet fields from the held address byte.
    logic [3:0] pkt_dev, pkt_mode;
    logic       bad_dev, bad_mode, bad_mag;
    logic [7:0] tx_mag;

    assign pop  = res.valid && res.ready;
    assign fire = item_valid_reg && ((pend_reg == 2'd0) || ((pend_reg == 2'd1) && pop));
    assign cmd.ready = !item_valid_reg || fire;

    assign scan_ok  = (scan_ptr_reg != 4'd0) && ({1'b0, scan_ptr_reg} < DEV_LIMIT);
    assign scan_p   = scan_ok ? scan_ptr_reg : 4'd1;
    assign scan_inc = {1'b0, scan_p} + 5'd1;
    assign scan_nx  = (scan_inc >= DEV_LIMIT) ? 4'd1 : scan_inc[3:0];

    assign rd_dev      = (item_reg.action == srms_pkg::ACT_SCAN) ? scan_p : item_reg.device;
    assign rd_in_range = ({1'b0, rd_dev} < DEV_LIMIT);
    assign rd_rmode    = rd_in_range ? rmode_reg[rd_dev[IDX_W-1:0]] : 4'd0;
    assign rd_rmag     = rd_in_range ? rmag_reg[rd_dev[IDX_W-1:0]]  : 8'd0;
    assign rd_lmode    = rd_in_range ? lmode_reg[rd_dev[IDX_W-1:0]] : 4'd0;
    assign rd_lmag     = rd_in_range ? lmag_reg[rd_dev[IDX_W-1:0]]  : 8'd0;

    assign pkt_dev  = held_reg[7:4];
    assign pkt_mode = held_reg[3:0];
    assign bad_dev  = (pkt_dev == srms_pkg::FIELD_BAD);
    assign bad_mode = (pkt_mode == srms_pkg::FIELD_BAD);
    assign bad_mag  = (item_reg.rx_byte == srms_pkg::MAG_INVALID);
    assign tx_mag   = (rd_lmag == srms_pkg::MAG_INVALID) ? srms_pkg::MAG_TX_CLAMP : rd_lmag;

    // Processing of the held item. State updates are only committed when fire is high.
    always_comb
    begin
        for (int k = 0; k < srms_pkg::RES_DEPTH; k++)
        begin
            new_res[k] = '0;
        end
        new_cnt       = 2'd0;
        phase_next    = phase_reg;
        held_next     = held_reg;
        scan_ptr_next = scan_ptr_reg;
        rwr_en        = 1'b0;
        rwr_idx       = pkt_dev[IDX_W-1:0];
        rwr_mode      = pkt_mode;
        rwr_mag       = item_reg.rx_byte;
        lwr_en        = 1'b0;
        lwr_idx       = rd_dev[IDX_W-1:0];
        lwr_mode      = item_reg.mode;
        lwr_mag       = item_reg.magnitude;

        unique case (item_reg.action)
            srms_pkg::ACT_RX_BYTE:
            begin
                unique case (phase_reg)
                    srms_pkg::PH_ADDR:
                    begin
                        held_next  = item_reg.rx_byte;
                        phase_next = srms_pkg::PH_MAG;
                    end
                    srms_pkg::PH_MAG:
                    begin
                        // Packet complete: report it and update the remote copy if valid.
                        phase_next      = srms_pkg::PH_HUNT;
                        new_cnt         = 2'd1;
                        new_res[0].last = 1'b1;
                        if (bad_dev || bad_mode || bad_mag)
                        begin
                            new_res[0].out_kind      = srms_pkg::KIND_REJECTED;
                            new_res[0].bad_device    = bad_dev;
                            new_res[0].bad_mode      = bad_mode;
                            new_res[0].bad_magnitude = bad_mag;
                        end
                        else
                        begin
                            rwr_en = ({1'b0, pkt_dev} < DEV_LIMIT);
                            new_res[0].out_kind         = srms_pkg::KIND_ACCEPTED;
                            new_res[0].remote_mode      = pkt_mode;
                            new_res[0].remote_magnitude = item_reg.rx_byte;
                        end
                    end
                    default:
                    begin
                        phase_next = (item_reg.rx_byte == srms_pkg::MARKER_BYTE)
                                     ? srms_pkg::PH_ADDR : srms_pkg::PH_HUNT;
                    end
                endcase
            end
            srms_pkg::ACT_SET_LOCAL:
            begin
                lwr_en = rd_in_range;
            end
            srms_pkg::ACT_SCAN:
            begin
                scan_ptr_next = scan_nx;
                if ((rd_lmode != rd_rmode) || (rd_lmag != rd_rmag))
                begin
                    if (!mask_reg[scan_p])
                    begin
                        // Not writable: the remote side wins.
                        lwr_en   = 1'b1;
                        lwr_mode = rd_rmode;
                        lwr_mag  = rd_rmag;
                    end
                    else
                    begin
                        // Writable: push the local values as a three-byte packet.
                        new_cnt            = 2'd3;
                        new_res[0].tx_byte = srms_pkg::MARKER_BYTE;
                        new_res[1].tx_byte = {scan_p, rd_lmode};
                        new_res[2].tx_byte = tx_mag;
                        new_res[2].last    = 1'b1;
                    end
                end
            end
            srms_pkg::ACT_READ:
            begin
                new_cnt                     = 2'd1;
                new_res[0].out_kind         = srms_pkg::KIND_READ;
                new_res[0].remote_mode      = rd_rmode;
                new_res[0].remote_magnitude = rd_rmag;
                new_res[0].local_mode       = rd_lmode;
                new_res[0].local_magnitude  = rd_lmag;
                new_res[0].last             = 1'b1;
            end
        endcase
    end

    // Control and table state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= srms_pkg::PH_HUNT;
            held_reg       <= 8'd0;
            scan_ptr_reg   <= 4'd1;
            mask_reg       <= '0;
            item_valid_reg <= 1'b0;
            pend_reg       <= 2'd0;
            for (int d = 0; d < DEVICE_COUNT; d++)
            begin
                rmode_reg[d] <= 4'd0;
                rmag_reg[d]  <= 8'd0;
                lmode_reg[d] <= 4'd0;
                lmag_reg[d]  <= 8'd0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end

            if (cmd.valid && cmd.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                pend_reg <= new_cnt;
            end
            else if (pop)
            begin
                pend_reg <= pend_reg - 2'd1;
            end

            if (fire)
            begin
                phase_reg    <= phase_next;
                held_reg     <= held_next;
                scan_ptr_reg <= scan_ptr_next;
                if (rwr_en)
                begin
                    rmode_reg[rwr_idx] <= rwr_mode;
                    rmag_reg[rwr_idx]  <= rwr_mag;
                end
                if (lwr_en)
                begin
                    lmode_reg[lwr_idx] <= lwr_mode;
                    lmag_reg[lwr_idx]  <= lwr_mag;
                end
            end
        end
    end

    // Payload registers: the held item and the result buffer.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.action    <= cmd.action;
            item_reg.rx_byte   <= cmd.rx_byte;
            item_reg.device    <= cmd.device;
            item_reg.mode      <= cmd.mode;
            item_reg.magnitude <= cmd.magnitude;
        end

        if (fire)
        begin
            for (int k = 0; k < srms_pkg::RES_DEPTH; k++)
            begin
                res_buf_reg[k] <= new_res[k];
            end
        end
        else if (pop)
        begin
            for (int k = 0; k < srms_pkg::RES_DEPTH - 1; k++)
            begin
                res_buf_reg[k] <= res_buf_reg[k + 1];
            end
        end
    end

    assign res.valid            = (pend_reg != 2'd0);
    assign res.out_kind         = res_buf_reg[0].out_kind;
    assign res.tx_byte          = res_buf_reg[0].tx_byte;
    assign res.remote_mode      = res_buf_reg[0].remote_mode;
    assign res.remote_magnitude = res_buf_reg[0].remote_magnitude;
    assign res.local_mode       = res_buf_reg[0].local_mode;
    assign res.local_magnitude  = res_buf_reg[0].local_magnitude;
    assign res.bad_device       = res_buf_reg[0].bad_device;
    assign res.bad_mode         = res_buf_reg[0].bad_mode;
    assign res.bad_magnitude    = res_buf_reg[0].bad_magnitude;
    assign res.last             = res_buf_reg[0].last;

endmodule

// File: test/srms_checker.sv
`timescale 1ns / 100ps
// Checker for the serial register mirror: mirrors the tables, predicts and compares results.
module srms_checker
    import srms_pkg::*;
#(
    parameter int unsigned DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    srms_cmd_if               cmd,
    srms_res_if               res,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending
);

    logic [3:0]        rem_mode [16];
    logic [7:0]        rem_mag  [16];
    logic [3:0]        loc_mode [16];
    logic [7:0]        loc_mag  [16];
    phase_t            phase;
    logic [7:0]        held_addr;
    logic [3:0]        scan_ptr;
    logic [MASK_W-1:0] push_mask;
    res_t              expected_q [$];
    int                errors = 0;

    // Serial byte parser: a result only comes out when the magnitude byte completes a packet.
    task automatic parse_byte(input logic [7:0] b);
        res_t       r;
        logic [3:0] dev;
        logic [3:0] md;
        case (phase)
            PH_ADDR:
            begin
                held_addr = b;
                phase = PH_MAG;
            end
            PH_MAG:
            begin
                phase = PH_HUNT;
                dev = held_addr[7:4];
                md = held_addr[3:0];
                r = '0;
                r.last = 1'b1;
                if (dev == FIELD_BAD || md == FIELD_BAD || b == MAG_INVALID)
                begin
                    r.out_kind = KIND_REJECTED;
                    r.bad_device = (dev == FIELD_BAD);
                    r.bad_mode = (md == FIELD_BAD);
                    r.bad_magnitude = (b == MAG_INVALID);
                end
                else
                begin
                    if (dev < DEVICE_COUNT)
                    begin
                        rem_mode[dev] = md;
                        rem_mag[dev] = b;
                    end
                    r.out_kind = KIND_ACCEPTED;
                    r.remote_mode = md;
                    r.remote_magnitude = b;
                end
                expected_q.push_back(r);
            end
            default:
                phase = (b == MARKER_BYTE) ? PH_ADDR : PH_HUNT;
        endcase
    endtask

    // One scan tick: resync one device if its copies differ, either by sending a packet or by pulling remote values.
    task automatic scan_device();
        res_t        r;
        int unsigned p;
        int unsigned nx;
        logic [7:0]  sent_mag;
        p = scan_ptr;
        if (p < 1 || p >= DEVICE_COUNT)
            p = 1;
        nx = p + 1;
        if (nx >= DEVICE_COUNT)
            nx = 1;
        scan_ptr = 4'(nx);
        if (loc_mode[p] == rem_mode[p] && loc_mag[p] == rem_mag[p])
            return;
        if (!push_mask[p])
        begin
            loc_mode[p] = rem_mode[p];
            loc_mag[p] = rem_mag[p];
            return;
        end
        sent_mag = (loc_mag[p] == MAG_INVALID) ? MAG_TX_CLAMP : loc_mag[p];
        r = '0;
        r.out_kind = KIND_TX_BYTE;
        r.tx_byte = MARKER_BYTE;
        expected_q.push_back(r);
        r.tx_byte = {p[3:0], loc_mode[p]};
        expected_q.push_back(r);
        r.tx_byte = sent_mag;
        r.last = 1'b1;
        expected_q.push_back(r);
    endtask

    task automatic predict_item(input action_t act, input logic [7:0] rxb, input logic [3:0] dev,
                                input logic [3:0] md, input logic [7:0] mag);
        res_t r;
        case (act)
            ACT_RX_BYTE:
                parse_byte(rxb);
            ACT_SET_LOCAL:
            begin
                if (dev < DEVICE_COUNT)
                begin
                    loc_mode[dev] = md;
                    loc_mag[dev] = mag;
                end
            end
            ACT_SCAN:
                scan_device();
            default:
            begin
                r = '0;
                r.out_kind = KIND_READ;
                r.last = 1'b1;
                if (dev < DEVICE_COUNT)
                begin
                    r.remote_mode = rem_mode[dev];
                    r.remote_magnitude = rem_mag[dev];
                    r.local_mode = loc_mode[dev];
                    r.local_magnitude = loc_mag[dev];
                end
                expected_q.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rem_mode[i] = '0;
                rem_mag[i] = '0;
                loc_mode[i] = '0;
                loc_mag[i] = '0;
            end
            phase = PH_HUNT;
            held_addr = '0;
            scan_ptr = 4'd1;
            push_mask = '0;
            expected_q.delete();
            pending <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (cfg_wr_en)
                push_mask = cfg_wr_data;
            if (cmd.valid && cmd.ready)
                predict_item(cmd.action, cmd.rx_byte, cmd.device, cmd.mode, cmd.magnitude);
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no item expected: kind %0d", res.out_kind);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("out_kind", e.out_kind, res.out_kind);
                    check_field("tx_byte", e.tx_byte, res.tx_byte);
                    check_field("remote_mode", e.remote_mode, res.remote_mode);
                    check_field("remote_magnitude", e.remote_magnitude, res.remote_magnitude);
                    check_field("local_mode", e.local_mode, res.local_mode);
                    check_field("local_magnitude", e.local_magnitude, res.local_magnitude);
                    check_field("bad_device", e.bad_device, res.bad_device);
                    check_field("bad_mode", e.bad_mode, res.bad_mode);
                    check_field("bad_magnitude", e.bad_magnitude, res.bad_magnitude);
                    check_field("last", e.last, res.last);
                end
            end
            pending <= expected_q.size();
            fail_count <= errors;
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus, stall patterns and verdict for the mirror block.
module tb;
    import srms_pkg::*;

    // The limit lies far above the length of any legal run, even with heavy stalls,
    // so it only catches a hang or a lost result.
    localparam int CYCLE_LIMIT = 300000;
    // An item that produces no result can still sit in the input register after
    // the last result has drained; this pause covers that.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 56;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MASK_W-1:0] cfg_wr_data;
    int                fail_count;
    int                pending_items;
    int                src_idle_pct = 21;
    int                snk_idle_pct = 84;
    int                cycles = 0;

    srms_cmd_if cmd_ch ();
    srms_res_if res_ch ();

    serial_register_mirror_sync u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    srms_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending_items)
    );

    always #1 clk = ~clk;

    // The result side stalls at random with the current percentage; when it is
    // zero the receiver takes every result as soon as it is offered.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: a run that never drains its expected results ends here as a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Every item starts from random contents so that the fields an action ignores
    // still see both values on every bit; the caller then fills the ones that matter.
    function automatic cmd_t random_cmd(input action_t act);
        logic [31:0] bits;
        cmd_t        c;
        bits = $urandom;
        c = cmd_t'(bits[$bits(cmd_t)-1:0]);
        c.action = act;
        return c;
    endfunction

    // A mode or device nibble that is usually legal but sometimes the reserved 15.
    function automatic logic [3:0] pick_nibble();
        return ($urandom_range(7) == 0) ? FIELD_BAD : 4'($urandom_range(14));
    endfunction

    // A magnitude that hits 255 often enough to exercise rejection and the transmit clamp.
    function automatic logic [7:0] pick_mag();
        return ($urandom_range(7) == 0) ? MAG_INVALID : 8'($urandom_range(255));
    endfunction

    // Offers one item and returns once it has been accepted. The sender may idle
    // first; valid stays high into the next item otherwise.
    task automatic send_item(input cmd_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.action    <= c.action;
        cmd_ch.rx_byte   <= c.rx_byte;
        cmd_ch.device    <= c.device;
        cmd_ch.mode      <= c.mode;
        cmd_ch.magnitude <= c.magnitude;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        cmd_t c;
        c = random_cmd(ACT_RX_BYTE);
        c.rx_byte = b;
        send_item(c);
    endtask

    task automatic send_packet(input logic [7:0] addr, input logic [7:0] mag);
        send_byte(MARKER_BYTE);
        send_byte(addr);
        send_byte(mag);
    endtask

    task automatic send_set(input logic [3:0] dev, input logic [3:0] md, input logic [7:0] mag);
        cmd_t c;
        c = random_cmd(ACT_SET_LOCAL);
        c.device = dev;
        c.mode = md;
        c.magnitude = mag;
        send_item(c);
    endtask

    task automatic send_scan();
        send_item(random_cmd(ACT_SCAN));
    endtask

    task automatic send_read(input logic [3:0] dev);
        cmd_t c;
        c = random_cmd(ACT_READ);
        c.device = dev;
        send_item(c);
    endtask

    // Lowers valid, waits until the checker holds no more expectations, then lets
    // the block settle so that a following register write finds it idle.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_items != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic: mostly well-formed packets, local updates, scans and reads,
    // with some stray bytes mixed in. Stray bytes do not count toward the total,
    // since in the hunting state the block drops any that is not the marker byte.
    task automatic random_items(input int n);
        int count;
        int pick;
        count = 0;
        while (count < n)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                send_packet({pick_nibble(), pick_nibble()}, pick_mag());
                count += 3;
            end
            else if (pick < 55)
            begin
                send_set(4'($urandom_range(15)), pick_nibble(), pick_mag());
                count++;
            end
            else if (pick < 74)
            begin
                send_scan();
                count++;
            end
            else if (pick < 90)
            begin
                send_read(4'($urandom_range(15)));
                count++;
            end
            else if (pick < 95)
            begin
                // A broken packet: the marker is followed by a second marker, which
                // the parser takes as the address byte.
                send_byte(MARKER_BYTE);
                send_byte(MARKER_BYTE);
                send_byte(8'($urandom_range(255)));
                count += 3;
            end
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.action    <= ACT_RX_BYTE;
        cmd_ch.rx_byte   <= '0;
        cmd_ch.device    <= '0;
        cmd_ch.mode      <= '0;
        cmd_ch.magnitude <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with only device 1 writable.
        write_mask(16'h0002);
        send_read(4'd0);                  // fresh tables read back as zero
        send_byte(8'h12);                 // dropped while hunting for the marker
        send_packet(8'h35, 8'h80);        // device 3 accepted, remote copy written
        send_packet(MARKER_BYTE, 8'h00);  // marker as address: bad device and mode
        send_packet(8'hf0, 8'h00);        // bad device alone
        send_packet(8'h1f, MAG_INVALID);  // bad mode and bad magnitude
        send_packet(8'hee, 8'hfe);        // largest legal device, mode and magnitude
        send_set(4'd1, 4'hf, MAG_INVALID);
        send_scan();                      // device 1 writable: packet with 255 sent as 254
        send_scan();                      // device 2 matches: nothing happens
        send_scan();                      // device 3 not writable: remote copied into local
        send_read(4'd3);
        send_set(4'd15, 4'hf, 8'hff);
        send_read(4'd15);
        send_set(4'd0, 4'h0, 8'h00);
        send_read(4'd14);
        wait_drained();

        // Random part in three stall phases, each with its own mask.
        write_mask(16'hffff);
        random_items(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 84;
        snk_idle_pct = 21;
        write_mask(16'h0000);
        random_items(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_mask(16'($urandom));
        random_items(PHASE_ITEMS);
        wait_drained();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
